@@ hdl/cifc_pkg.sv @@
// Shared types, constants and ID tables for the CAN ID class filter and cache.
package cifc_pkg;

    // Field widths
    localparam int ID_W      = 29;
    localparam int STD_W     = 11;
    localparam int DATA_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 29;
    localparam int CNT_REG_W = 3;
    localparam int IN_W      = 96;
    localparam int OUT_W     = 8;

    // Parameter defaults
    localparam int CACHE_ENTRIES_DEF = 32;
    localparam int USER_ID_SLOTS_DEF = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUS_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USER_BASE  = 3'd2;

    localparam logic [ID_W-1:0] PRIORITY_ID = 29'h18FF0800;

    // Frame classes
    typedef enum logic [1:0] {
        CLS_DROP       = 2'd0,
        CLS_FWD_CACHE  = 2'd1,
        CLS_FWD_ONLY   = 2'd2,
        CLS_CACHE_ONLY = 2'd3
    } frame_class_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic latch_class;
        logic rd_en;
        logic cache_wr;
        logic mark_full;
        logic load_result;
    } cifc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic want_cache;
        logic hit;
        logic last;
    } cifc_sts_t;

    // Lower-bus forward-only IDs
    localparam int LOWER_COUNT = 110;
    localparam logic [ID_W-1:0] LOWER_IDS [LOWER_COUNT] = '{
        29'h1CF23B21, 29'h1CF23F21, 29'h1CF21D21, 29'h1CF25E21, 29'h1CF22D21, 29'h1CF28B21,
        29'h1CF25C21, 29'h1CF25D21, 29'h1CF23A21, 29'h1CF24B21, 29'h1CF25C21,
        29'h1CF28C21, 29'h1CF40D21, 29'h1CF20F21, 29'h1CF21F21, 29'h1CF22F21, 29'h1CF29F21,
        29'h0CF00300, 29'h0CF00400, 29'h0CF0233D, 29'h18E00021, 29'h18F00A00, 29'h18F00E51,
        29'h18F00F52, 29'h18FCBD3D, 29'h18FD0700, 29'h18FD2000, 29'h18FD3E3D, 29'h18FD7C00,
        29'h18FD9BA3, 29'h18FDB200, 29'h18FE56A3, 29'h18FE563D, 29'h18FECA00, 29'h18ECFF00,
        29'h18EBFF00, 29'h18FEDF00, 29'h18FEDF3D, 29'h18FEE000, 29'h18FEE500, 29'h18FEE900,
        29'h18FEEE00, 29'h18FEEF00, 29'h18FEF100, 29'h18FEF200, 29'h18FEF500, 29'h18FEF600,
        29'h18FEFC17, 29'h18FEFF00, 29'h18FF1400, 29'h18FF203D, 29'h1FFFFFFF,
        29'h20F, 29'h21D, 29'h21E, 29'h21F, 29'h22A, 29'h22B, 29'h22C, 29'h22D, 29'h22E,
        29'h22F, 29'h23A, 29'h23B, 29'h23F, 29'h24B, 29'h24D, 29'h24E, 29'h24F, 29'h25A,
        29'h25C, 29'h25D, 29'h25E, 29'h25F, 29'h26A, 29'h28C, 29'h28D, 29'h29F, 29'h2BB,
        29'h2BC, 29'h2BD, 29'h2BE, 29'h2AB, 29'h2AC, 29'h2AD, 29'h2AE, 29'h2AF,
        29'h20A, 29'h20B, 29'h20C, 29'h20D, 29'h20E, 29'h21A, 29'h21B, 29'h21C, 29'h24A,
        29'h40A, 29'h40C, 29'h40D, 29'h41A, 29'h41B, 29'h41C, 29'h41D, 29'h42A, 29'h42B,
        29'h42C, 29'h46A, 29'h46B, 29'h46C, 29'h46D
    };

    // Upper-bus forward-only IDs
    localparam int UPPER_COUNT = 90;
    localparam logic [ID_W-1:0] UPPER_IDS [UPPER_COUNT] = '{
        29'h181, 29'h183, 29'h185, 29'h188, 29'h191, 29'h193, 29'h195, 29'h1A3, 29'h1B1,
        29'h1B2, 29'h1B3, 29'h1C3, 29'h1C5, 29'h1D1, 29'h1D5, 29'h1E3, 29'h1E9, 29'h1F3,
        29'h203, 29'h263, 29'h264, 29'h273, 29'h283, 29'h285, 29'h288, 29'h291, 29'h293,
        29'h295, 29'h2A3, 29'h2B3, 29'h2C3, 29'h2E3, 29'h2F3, 29'h343, 29'h35A, 29'h35B,
        29'h35C, 29'h35D, 29'h35E, 29'h35F, 29'h363, 29'h364, 29'h36A, 29'h36B, 29'h36C,
        29'h373, 29'h381, 29'h382, 29'h385, 29'h388, 29'h391, 29'h393, 29'h394, 29'h395,
        29'h3A1, 29'h3B3, 29'h3C3, 29'h3D3, 29'h3E3, 29'h3E4, 29'h3E5, 29'h3F3, 29'h3F5,
        29'h443, 29'h463, 29'h464, 29'h473, 29'h482, 29'h488, 29'h493, 29'h4A3, 29'h4B3,
        29'h4C1, 29'h4C3, 29'h4D3, 29'h4E3, 29'h4E4, 29'h4F3, 29'h504, 29'h50E, 29'h561,
        29'h562, 29'h564, 29'h565, 29'h571, 29'h572, 29'h573, 29'h574, 29'h575,
        29'h1FFFFFFE
    };

    // Constant-table membership: independent equality compares, OR-reduced
    function automatic logic lower_hit(input logic [ID_W-1:0] id);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < LOWER_COUNT; i++) begin
            hit = hit | (LOWER_IDS[i] == id);
        end
        return hit;
    endfunction

    function automatic logic upper_hit(input logic [ID_W-1:0] id);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < UPPER_COUNT; i++) begin
            hit = hit | (UPPER_IDS[i] == id);
        end
        return hit;
    endfunction

endpackage

@@ hdl/can_id_class_filter_cache.sv @@
// Top level of the CAN ID class filter with frame cache.
// Each received frame is classified in priority order: the fixed priority ID
// (forward and cache), the first user_id_count configured user IDs (cache
// only), then the selected bus's fixed ID table (forward only); anything else
// is dropped. Frames to be cached walk the cache from entry 0 and land in the
// first entry that holds the same ID or is empty; with no such entry the
// frame is not stored and cache_full is set. One item is handled at a time:
// a frame that is not cached passes through the classify and finish states;
// a cached frame also walks the single-port ID memory at one entry per cycle.
// The finish state waits while an unaccepted result is held. A finished
// result waits in the output register while the next item is taken in. The
// cache is empty right after reset; no clearing pass is needed.
module can_id_class_filter_cache #(
    parameter int CACHE_ENTRIES = cifc_pkg::CACHE_ENTRIES_DEF,
    parameter int USER_ID_SLOTS = cifc_pkg::USER_ID_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [cifc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cifc_pkg::CFG_W-1:0]      cfg_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cifc_pkg::IN_W-1:0]       s_tdata,  // id_is_extended, frame_id, frame_data
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cifc_pkg::OUT_W-1:0]      m_tdata   // frame_class, forward, cache_written,
                                                      // cache_full
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    cifc_pkg::cifc_cmd_t  cmd;
    cifc_pkg::cifc_sts_t  sts;
    logic [IDX_W-1:0]     rd_addr;

    cifc_ctrl #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .sts      (sts)
    );

    cifc_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .USER_ID_SLOTS (USER_ID_SLOTS),
        .IDX_W         (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .sts       (sts)
    );

endmodule

@@ hdl/cifc_ctrl.sv @@
// Controller state machine: sequences classification, cache walk and result hand-off.
module cifc_ctrl #(
    parameter int CACHE_ENTRIES = cifc_pkg::CACHE_ENTRIES_DEF,
    parameter int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output cifc_pkg::cifc_cmd_t cmd,
    output logic [IDX_W-1:0]    rd_addr,
    input  cifc_pkg::cifc_sts_t sts
);

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               out_valid_reg, out_valid_next;

    // Next-state and command logic
    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                cmd.latch_class = 1'b1;
                rd_idx_next     = '0;
                state_next      = sts.want_cache ? ST_WALK : ST_FINISH;
            end
            ST_WALK:
            begin
                // one read issued per cycle, compared when its registered data returns
                if (rd_idx_reg < CNT_W'(CACHE_ENTRIES))
                begin
                    cmd.rd_en   = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                priority if (sts.hit)
                begin
                    cmd.cache_wr = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (sts.last)
                begin
                    cmd.mark_full = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register valid
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign rd_addr  = rd_idx_reg[IDX_W-1:0];

endmodule

@@ hdl/cifc_datapath.sv @@
// Datapath: item and config registers, ID classification, cache memories, result register.
module cifc_datapath #(
    parameter int CACHE_ENTRIES = cifc_pkg::CACHE_ENTRIES_DEF,
    parameter int USER_ID_SLOTS = cifc_pkg::USER_ID_SLOTS_DEF,
    parameter int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cifc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cifc_pkg::CFG_W-1:0]       cfg_data,
    input  logic [cifc_pkg::IN_W-1:0]        s_tdata,
    output logic [cifc_pkg::OUT_W-1:0]       m_tdata,
    input  cifc_pkg::cifc_cmd_t              cmd,
    input  logic [IDX_W-1:0]                 rd_addr,
    output cifc_pkg::cifc_sts_t              sts
);

    localparam int USR_DEPTH = (USER_ID_SLOTS > 0) ? USER_ID_SLOTS : 1;

    // Configuration
    logic                                 bus_select_reg;
    logic [cifc_pkg::CNT_REG_W-1:0]       user_count_reg;
    logic [cifc_pkg::ID_W-1:0]            user_id_reg [USR_DEPTH];

    // Current item
    logic [cifc_pkg::ID_W-1:0]            id_reg;
    logic [cifc_pkg::DATA_W-1:0]          data_reg;

    // Classification
    cifc_pkg::frame_class_t               class_comb, class_reg;
    logic [cifc_pkg::CNT_REG_W-1:0]       user_n;
    logic                                 user_hit;
    logic                                 rom_hit;

    // Cache storage and walk pipeline
    logic [cifc_pkg::ID_W-1:0]            id_mem  [CACHE_ENTRIES];
    logic [cifc_pkg::DATA_W-1:0]          pay_mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0]             valid_reg;
    logic [cifc_pkg::ID_W-1:0]            rd_id_reg;
    logic                                 rd_ent_vld_reg;
    logic [IDX_W-1:0]                     rd_addr_reg;
    logic                                 rd_issued_reg;
    logic [cifc_pkg::ID_W-1:0]            rd_entry;

    // Result flags and output register
    logic                                 wr_flag_reg;
    logic                                 full_flag_reg;
    cifc_pkg::frame_class_t               res_class_reg;
    logic                                 res_fwd_reg;
    logic                                 res_wr_reg;
    logic                                 res_full_reg;

    // Config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_select_reg <= 1'b0;
            user_count_reg <= '0;
            for (int i = 0; i < USR_DEPTH; i++)
            begin
                user_id_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == cifc_pkg::REG_BUS_SELECT)
            begin
                bus_select_reg <= cfg_data[0];
            end
            if (cfg_index == cifc_pkg::REG_USER_COUNT)
            begin
                user_count_reg <= cfg_data[cifc_pkg::CNT_REG_W-1:0];
            end
            for (int i = 0; i < USER_ID_SLOTS; i++)
            begin
                if (cfg_index == cifc_pkg::REG_USER_BASE + cifc_pkg::CFG_IDX_W'(i))
                begin
                    user_id_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Item capture; standard IDs keep the low 11 bits
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            if (s_tdata[0])
            begin
                id_reg <= s_tdata[cifc_pkg::ID_W:1];
            end
            else
            begin
                id_reg <= {{(cifc_pkg::ID_W - cifc_pkg::STD_W){1'b0}},
                           s_tdata[cifc_pkg::STD_W:1]};
            end
            data_reg <= s_tdata[cifc_pkg::ID_W + cifc_pkg::DATA_W:cifc_pkg::ID_W + 1];
        end
    end

    // Classification: priority ID, then user slots, then bus ROM table
    always_comb
    begin
        user_n = (user_count_reg > cifc_pkg::CNT_REG_W'(USER_ID_SLOTS))
               ? cifc_pkg::CNT_REG_W'(USER_ID_SLOTS) : user_count_reg;
        user_hit = 1'b0;
        for (int i = 0; i < USER_ID_SLOTS; i++)
        begin
            if ((cifc_pkg::CNT_REG_W'(i) < user_n) && (user_id_reg[i] == id_reg))
            begin
                user_hit = 1'b1;
            end
        end
        rom_hit = bus_select_reg ? cifc_pkg::upper_hit(id_reg) : cifc_pkg::lower_hit(id_reg);
        priority if (id_reg == cifc_pkg::PRIORITY_ID)
        begin
            class_comb = cifc_pkg::CLS_FWD_CACHE;
        end
        else if (user_hit)
        begin
            class_comb = cifc_pkg::CLS_CACHE_ONLY;
        end
        else if (rom_hit)
        begin
            class_comb = cifc_pkg::CLS_FWD_ONLY;
        end
        else
        begin
            class_comb = cifc_pkg::CLS_DROP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_class)
        begin
            class_reg <= class_comb;
        end
    end

    // Cache memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.cache_wr)
        begin
            id_mem[rd_addr_reg]  <= id_reg;
            pay_mem[rd_addr_reg] <= data_reg;
        end
        rd_id_reg      <= id_mem[rd_addr];
        rd_ent_vld_reg <= valid_reg[rd_addr];
        rd_addr_reg    <= rd_addr;
    end

    // Entry valid bits and walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_issued_reg <= 1'b0;
            wr_flag_reg   <= 1'b0;
            full_flag_reg <= 1'b0;
        end
        else
        begin
            rd_issued_reg <= cmd.rd_en;
            if (cmd.cache_wr)
            begin
                valid_reg[rd_addr_reg] <= 1'b1;
            end
            if (cmd.latch_class)
            begin
                wr_flag_reg   <= 1'b0;
                full_flag_reg <= 1'b0;
            end
            else
            begin
                if (cmd.cache_wr)
                begin
                    wr_flag_reg <= 1'b1;
                end
                if (cmd.mark_full)
                begin
                    full_flag_reg <= 1'b1;
                end
            end
        end
    end

    // Unwritten entries read as empty
    assign rd_entry = rd_ent_vld_reg ? rd_id_reg : '0;

    assign sts.want_cache = (class_comb == cifc_pkg::CLS_FWD_CACHE)
                         || (class_comb == cifc_pkg::CLS_CACHE_ONLY);
    assign sts.hit  = rd_issued_reg && ((rd_entry == id_reg) || (rd_entry == '0));
    assign sts.last = rd_issued_reg && (rd_addr_reg == IDX_W'(CACHE_ENTRIES - 1));

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            res_class_reg <= class_reg;
            res_fwd_reg   <= (class_reg == cifc_pkg::CLS_FWD_CACHE)
                          || (class_reg == cifc_pkg::CLS_FWD_ONLY);
            res_wr_reg    <= wr_flag_reg;
            res_full_reg  <= full_flag_reg;
        end
    end

    assign m_tdata = {3'b000, res_full_reg, res_wr_reg, res_fwd_reg, res_class_reg};

endmodule

@@ hdl/cifc_checker.sv @@
// Port-level checker for the CAN ID class filter, bound to the top level.
module cifc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cifc_pkg::OUT_W-1:0]  m_tdata
);

    // Held result must not change while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Forward flag follows the class
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2] == ((m_tdata[1:0] == cifc_pkg::CLS_FWD_CACHE)
                                  || (m_tdata[1:0] == cifc_pkg::CLS_FWD_ONLY))))
        else $error("forward flag does not match class");

    // Non-caching classes report no cache activity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tdata[1:0] == cifc_pkg::CLS_DROP)
                  || (m_tdata[1:0] == cifc_pkg::CLS_FWD_ONLY))
        |-> !m_tdata[3] && !m_tdata[4])
        else $error("cache flags set for non-caching class");

    // Caching classes either stored or found the cache full, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tdata[1:0] == cifc_pkg::CLS_FWD_CACHE)
                  || (m_tdata[1:0] == cifc_pkg::CLS_CACHE_ONLY))
        |-> (m_tdata[3] != m_tdata[4]))
        else $error("cache written and cache full inconsistent");

endmodule

bind can_id_class_filter_cache cifc_checker u_cifc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/tb_can_id_class_filter_cache.sv @@
// Testbench for the CAN ID class filter and frame cache: predicted results, stream checks.
`timescale 1ns / 1ps

module tb_can_id_class_filter_cache;

    localparam int CACHE_SLOTS = cifc_pkg::CACHE_ENTRIES_DEF;
    localparam int USER_SLOTS  = cifc_pkg::USER_ID_SLOTS_DEF;
    localparam logic [cifc_pkg::ID_W-1:0] ID_MAX  = 29'h1FFFFFFF;
    localparam logic [cifc_pkg::ID_W-1:0] STD_MAX = 29'h7FF;
    localparam int POOL_SIZE   = 16;

    // Expected outcome of one frame
    typedef struct {
        cifc_pkg::frame_class_t cls;
        logic                   fwd;
        logic                   wr;
        logic                   full;
    } verdict_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [cifc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cifc_pkg::CFG_W-1:0]     cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cifc_pkg::IN_W-1:0]      s_tdata;   // id_is_extended, frame_id, frame_data
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cifc_pkg::OUT_W-1:0]     m_tdata;   // frame_class, forward, cache_written,
                                               // cache_full

    // Shadow copy of configuration and cache
    logic                           bus_sel;
    logic [cifc_pkg::CNT_REG_W-1:0] user_count;
    logic [cifc_pkg::ID_W-1:0]      user_ids [USER_SLOTS];
    logic [cifc_pkg::ID_W-1:0]      cached_id [CACHE_SLOTS];
    logic [cifc_pkg::DATA_W-1:0]    cached_data [CACHE_SLOTS];
    logic [cifc_pkg::ID_W-1:0]      id_pool [POOL_SIZE];

    verdict_t    verdict_q [$];
    int          mismatches;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          hold_cycles;

    can_id_class_filter_cache u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 50)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Fixed table of the selected bus
    function automatic logic in_bus_table(input logic [cifc_pkg::ID_W-1:0] id);
        logic hit;
        hit = 1'b0;
        if (bus_sel)
        begin
            for (int i = 0; i < cifc_pkg::UPPER_COUNT; i++)
                if (cifc_pkg::UPPER_IDS[i] == id) hit = 1'b1;
        end
        else
        begin
            for (int i = 0; i < cifc_pkg::LOWER_COUNT; i++)
                if (cifc_pkg::LOWER_IDS[i] == id) hit = 1'b1;
        end
        return hit;
    endfunction

    // Classify one frame and update the shadow cache
    function automatic verdict_t classify_frame(input logic ext,
                                                input logic [cifc_pkg::ID_W-1:0] raw_id,
                                                input logic [cifc_pkg::DATA_W-1:0] data);
        verdict_t                  v;
        logic [cifc_pkg::ID_W-1:0] id;
        int                        live;
        logic                      want;
        logic                      stored;
        v.cls  = cifc_pkg::CLS_DROP;
        v.fwd  = 1'b0;
        v.wr   = 1'b0;
        v.full = 1'b0;
        want   = 1'b0;
        stored = 1'b0;
        id     = ext ? raw_id
                     : {{(cifc_pkg::ID_W-cifc_pkg::STD_W){1'b0}}, raw_id[cifc_pkg::STD_W-1:0]};
        live   = (int'(user_count) > USER_SLOTS) ? USER_SLOTS : int'(user_count);
        if (id == cifc_pkg::PRIORITY_ID)
        begin
            v.cls = cifc_pkg::CLS_FWD_CACHE;
            v.fwd = 1'b1;
            want  = 1'b1;
        end
        else
        begin
            for (int i = 0; i < live; i++)
                if (user_ids[i] == id) want = 1'b1;
            if (want)
            begin
                v.cls = cifc_pkg::CLS_CACHE_ONLY;
            end
            else if (in_bus_table(id))
            begin
                v.cls = cifc_pkg::CLS_FWD_ONLY;
                v.fwd = 1'b1;
            end
        end
        // first entry that holds this ID or is empty
        if (want)
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                if (!stored && (cached_id[i] == id || cached_id[i] == '0))
                begin
                    cached_id[i]   = id;
                    cached_data[i] = data;
                    stored         = 1'b1;
                end
            end
            v.wr   = stored;
            v.full = !stored;
        end
        return v;
    endfunction

    task automatic write_reg(input logic [cifc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cifc_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == cifc_pkg::REG_BUS_SELECT)
            bus_sel = value[0];
        else if (idx == cifc_pkg::REG_USER_COUNT)
            user_count = value[cifc_pkg::CNT_REG_W-1:0];
        else
            user_ids[idx - cifc_pkg::REG_USER_BASE] = value[cifc_pkg::ID_W-1:0];
    endtask

    task automatic send_frame(input logic ext, input logic [cifc_pkg::ID_W-1:0] id,
                              input logic [cifc_pkg::DATA_W-1:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, data, id, ext};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        verdict_q.push_back(classify_frame(ext, id, data));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [cifc_pkg::DATA_W-1:0] rand_payload();
        int kind;
        kind = $urandom_range(9);
        if (kind == 0) return '0;
        if (kind == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // Mostly IDs that hit a rule, the rest noise
    task automatic send_random_frame();
        logic [cifc_pkg::ID_W-1:0] base;
        logic [cifc_pkg::ID_W-1:0] garbage;
        logic                      ext;
        int                        kind;
        kind    = $urandom_range(9);
        garbage = cifc_pkg::ID_W'($urandom) << cifc_pkg::STD_W;
        unique case (kind)
            0:       base = cifc_pkg::PRIORITY_ID;
            1, 2, 3: base = user_ids[$urandom_range(USER_SLOTS-1)];
            4:       base = cifc_pkg::LOWER_IDS[$urandom_range(cifc_pkg::LOWER_COUNT-1)];
            5:       base = cifc_pkg::UPPER_IDS[$urandom_range(cifc_pkg::UPPER_COUNT-1)];
            6:       base = '0;
            7:       base = ID_MAX;
            default: base = cifc_pkg::ID_W'($urandom);
        endcase
        if (base <= STD_MAX || kind >= 8)
            ext = 1'($urandom_range(1));
        else
            ext = 1'b1;
        send_frame(ext, ext ? base : (base | garbage), rand_payload());
    endtask

    task automatic random_config();
        write_reg(cifc_pkg::REG_BUS_SELECT, cifc_pkg::CFG_W'($urandom_range(1)));
        write_reg(cifc_pkg::REG_USER_COUNT, cifc_pkg::CFG_W'($urandom_range(7)));
        for (int i = 0; i < USER_SLOTS; i++)
            write_reg(cifc_pkg::REG_USER_BASE + cifc_pkg::CFG_IDX_W'(i),
                      id_pool[$urandom_range(POOL_SIZE-1)]);
    endtask

    // Rule order, table ends, standard ID masking, user slot limits
    task automatic test_directed();
        send_frame(1'b1, cifc_pkg::PRIORITY_ID, '1);
        send_frame(1'b1, cifc_pkg::PRIORITY_ID, '0);
        send_frame(1'b0, cifc_pkg::PRIORITY_ID, 64'h0123_4567_89AB_CDEF);
        send_frame(1'b1, 29'h1CF23B21, '1);
        send_frame(1'b1, ID_MAX, '0);
        send_frame(1'b0, 29'h1FFFF20F, '1);
        send_frame(1'b1, 29'h20F, '0);
        send_frame(1'b1, 29'h181, '1);
        send_frame(1'b0, ID_MAX, '0);
        wait_drain();
        write_reg(cifc_pkg::REG_BUS_SELECT, 29'd1);
        send_frame(1'b1, 29'h181, '1);
        send_frame(1'b1, 29'h1FFFFFFE, '0);
        send_frame(1'b1, 29'h1CF23B21, '1);
        wait_drain();
        // count above the slot number counts as all slots
        write_reg(cifc_pkg::REG_USER_COUNT, 29'd7);
        write_reg(cifc_pkg::REG_USER_BASE + 3'd0, 29'h0);
        write_reg(cifc_pkg::REG_USER_BASE + 3'd1, ID_MAX);
        write_reg(cifc_pkg::REG_USER_BASE + 3'd2, cifc_pkg::PRIORITY_ID);
        write_reg(cifc_pkg::REG_USER_BASE + 3'd3, 29'h181);
        write_reg(cifc_pkg::REG_USER_BASE + 3'd4, STD_MAX);
        write_reg(cifc_pkg::REG_USER_BASE + 3'd5, 29'h12345678);
        send_frame(1'b1, 29'h0, '1);
        send_frame(1'b1, ID_MAX, '0);
        send_frame(1'b1, cifc_pkg::PRIORITY_ID, '1);
        send_frame(1'b0, 29'h181, '0);
        send_frame(1'b1, 29'h12345678, '1);
        wait_drain();
        write_reg(cifc_pkg::REG_USER_COUNT, 29'd5);
        send_frame(1'b1, 29'h12345678, '0);
        send_frame(1'b0, 29'h155557FF, '1);
        wait_drain();
        write_reg(cifc_pkg::REG_USER_COUNT, 29'd0);
        send_frame(1'b0, STD_MAX, '0);
        wait_drain();
        write_reg(cifc_pkg::REG_BUS_SELECT, 29'd0);
    endtask

    // Random frames; halfway the sender waits for all results and settings change
    task automatic test_random(input int count, input int unsigned send_pct,
                               input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_config();
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                wait_drain();
                random_config();
            end
            send_random_frame();
        end
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 300;
        for (int i = 0; i < 24; i++)
            send_random_frame();
        wait_drain();
    endtask

    // Fill every entry with fresh IDs, then overflow
    task automatic test_cache_fill();
        logic [cifc_pkg::ID_W-1:0] fresh [USER_SLOTS];
        logic [cifc_pkg::ID_W-1:0] first_fresh;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        first_fresh   = '0;
        write_reg(cifc_pkg::REG_USER_COUNT, cifc_pkg::CFG_W'(USER_SLOTS));
        for (int b = 0; b < 7; b++)
        begin
            for (int i = 0; i < USER_SLOTS; i++)
            begin
                fresh[i] = cifc_pkg::ID_W'($urandom) | 29'h0080_0000;
                write_reg(cifc_pkg::REG_USER_BASE + cifc_pkg::CFG_IDX_W'(i), fresh[i]);
            end
            if (b == 0) first_fresh = fresh[0];
            for (int i = 0; i < USER_SLOTS; i++)
                send_frame(1'b1, fresh[i], rand_payload());
            wait_drain();
        end
        // full cache: known IDs still update, ID zero finds no empty entry
        write_reg(cifc_pkg::REG_USER_BASE + 3'd0, '0);
        write_reg(cifc_pkg::REG_USER_BASE + 3'd1, first_fresh);
        send_frame(1'b1, 29'h0, '1);
        send_frame(1'b1, first_fresh, '0);
        send_frame(1'b1, cifc_pkg::PRIORITY_ID, '1);
        wait_drain();
    endtask

    // Receiver: random idling plus long hold-offs
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing expected", m_tdata));
            end
            else
            begin
                want = verdict_q.pop_front();
                if (m_tdata[1:0] !== want.cls)
                    report_mismatch($sformatf("frame_class got %0d want %0d",
                                              m_tdata[1:0], want.cls));
                if (m_tdata[2] !== want.fwd)
                    report_mismatch($sformatf("forward got %b want %b", m_tdata[2], want.fwd));
                if (m_tdata[3] !== want.wr)
                    report_mismatch($sformatf("cache_written got %b want %b",
                                              m_tdata[3], want.wr));
                if (m_tdata[4] !== want.full)
                    report_mismatch($sformatf("cache_full got %b want %b",
                                              m_tdata[4], want.full));
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        mismatches    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 0;
        bus_sel       = 1'b0;
        user_count    = '0;
        for (int i = 0; i < USER_SLOTS; i++) user_ids[i] = '0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            cached_id[i]   = '0;
            cached_data[i] = '0;
        end
        // user ID pool: zero, priority, table members, random IDs
        id_pool[0] = '0;
        id_pool[1] = cifc_pkg::PRIORITY_ID;
        id_pool[2] = 29'h1CF23B21;
        id_pool[3] = 29'h20A;
        id_pool[4] = 29'h181;
        id_pool[5] = 29'h1FFFFFFE;
        id_pool[6] = STD_MAX;
        for (int i = 7; i < 11; i++) id_pool[i] = cifc_pkg::ID_W'($urandom_range(2047));
        for (int i = 11; i < POOL_SIZE; i++) id_pool[i] = cifc_pkg::ID_W'($urandom);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(155, 36, 70);
        test_random(155, 70, 36);
        test_backpressure();
        test_cache_fill();
        test_random(155, 0, 0);

        wait_drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
